### sv/f2h_pkg.sv
// Package for the binary32 to binary16 converter.
// Shared constants for the half-precision result format; no dependencies.
package f2h_pkg;
  localparam logic [14:0] HalfMaxFinite = 15'h7BFF;
  localparam logic [14:0] HalfInf       = 15'h7C00;
  localparam logic [7:0]  SingleExpMax  = 8'hFF;
  // biased single exponents bounding the half ranges
  localparam logic [7:0]  ExpZeroBelow  = 8'd102;  // e < -25
  localparam logic [7:0]  ExpSubBelow   = 8'd113;  // e < -14
  localparam logic [7:0]  ExpOvfAbove   = 8'd142;  // e > 15
endpackage

### sv/fp32_to_fp16_convert_top.sv
// Binary32 to binary16 converter, round to nearest even.
// Depends on f2h_pkg.
//
// One request per clock while the output is taken: an input register feeds
// the conversion logic and a result register holds the result. An accepted
// request waits in the input register and is then loaded into the result
// register, which drives out_valid and half_bits.
// With the output being taken every cycle, a new request is accepted every
// cycle. An output stall holds the result register, and the input register
// too once it is full, so in_ready drops when both stages hold a request.
// The clip register, written through cfg_we, selects 0x7BFF or infinity on overflow.
module fp32_to_fp16_convert_top
  import f2h_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] single_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] half_bits
);
  logic        clip;
  logic        s1_valid;
  logic [31:0] s1_data;
  logic        s2_valid;
  logic [15:0] s2_data;
  logic        s1_adv;
  logic        s2_adv;
  logic [15:0] conv;

  // clip register
  always_ff @(posedge clk) begin
    if (rst) clip <= 1'b0;
    else if (cfg_we) clip <= cfg_wdata;
  end

  // each stage moves when the stage after it is free or being emptied
  assign s2_adv   = !s2_valid || out_ready;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
    if (s1_adv && in_valid) s1_data <= single_bits;
  end

  // conversion logic
  logic        sgn;
  logic [7:0]  bexp;
  logic [22:0] frac;
  logic [23:0] sig;
  logic [4:0]  sh;
  logic [23:0] sub_q;
  logic [23:0] sub_mask;
  logic        sub_half;
  logic        sub_stk;
  logic [10:0] sub_m;
  logic [10:0] nq;
  logic        nhalf;
  logic        nstk;
  logic [11:0] nm;
  logic [7:0]  ne;
  logic [9:0]  nanm;
  logic [10:0] nanr;
  logic [14:0] mag;

  always_comb begin
    sgn  = s1_data[31];
    bexp = s1_data[30:23];
    frac = s1_data[22:0];
    sig  = {1'b1, frac};
    // subnormal shift is 126 - bexp, 14..24
    sh       = 5'(8'd126 - bexp);
    sub_q    = sig >> sh;
    sub_half = sig[5'(sh - 5'd1)];
    sub_mask = (24'd1 << 5'(sh - 5'd1)) - 24'd1;
    sub_stk  = |(sig & sub_mask);
    sub_m    = sub_q[10:0] + 11'((sub_half && (sub_q[0] || sub_stk)) ? 1 : 0);
    // normal round at bit 13
    nq    = sig[23:13];
    nhalf = sig[12];
    nstk  = |sig[11:0];
    nm    = {1'b0, nq} + 12'((nhalf && (nq[0] || nstk)) ? 1 : 0);
    ne    = bexp - 8'd112;  // e + 15
    // NaN payload
    nanr  = {1'b0, frac[22:13]} + 11'((frac[12] && (frac[13] || |frac[11:0])) ? 1 : 0);
    nanm  = nanr[9:0];
    if (frac[22]) nanm[9] = 1'b1;
    else begin
      nanm[9] = 1'b0;
      if (nanm == 10'd0) nanm = 10'd1;
    end
    if (bexp == SingleExpMax) begin
      mag = (frac == 23'd0) ? HalfInf : (HalfInf | {5'd0, nanm});
    end else if (bexp < ExpZeroBelow) begin
      mag = 15'd0;
    end else if (bexp < ExpSubBelow) begin
      mag = {4'd0, sub_m};
    end else if (bexp > ExpOvfAbove ||
                 (bexp == ExpOvfAbove && nm[11])) begin
      mag = clip ? HalfMaxFinite : HalfInf;
    end else if (nm[11]) begin
      mag = {5'(ne + 8'd1), nm[10:1]};
    end else begin
      mag = {ne[4:0], nm[9:0]};
    end
    conv = {sgn, mag};
  end

  // result register, held while the output stalls
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (s2_adv) s2_valid <= s1_valid;
    if (s2_adv && s1_valid) s2_data <= conv;
  end

  assign out_valid = s2_valid;
  assign half_bits = s2_data;

  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !out_ready |=> out_valid && $stable(half_bits))
    else $error("result changed or lost under stall");
  assert property (@(posedge clk) disable iff (rst)
                   s1_valid && !s2_adv |=> s1_valid && $stable(s1_data))
    else $error("input register changed while held");
  assert property (@(posedge clk) disable iff (rst) !s2_valid |-> in_ready)
    else $error("input refused with result register empty");
  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> s1_valid)
    else $error("accepted request not held");
endmodule

### sim/fp32_to_fp16_convert_top_tb.sv
// Testbench for the binary32 to binary16 converter (fp32_to_fp16_convert_top).
// Checks every result against a built-in converter model; depends on f2h_pkg.
module fp32_to_fp16_convert_top_tb;
  import f2h_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] single_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] half_bits;

  logic        clip_mode = 1'b0;
  logic [15:0] expected_halves[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_cycles = 0;
  bit          failed = 1'b0;

  fp32_to_fp16_convert_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .single_bits(single_bits),
    .out_valid(out_valid), .out_ready(out_ready), .half_bits(half_bits)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shift right by n with round to nearest, ties to even
  function automatic logic [23:0] rne_shift(logic [23:0] v, int n);
    logic [23:0] q;
    logic        half_bit;
    logic        sticky;
    q = v >> n;
    half_bit = v[n-1];
    sticky = (v & ((24'd1 << (n - 1)) - 24'd1)) != 0;
    if (half_bit && (q[0] || sticky)) q = q + 24'd1;
    return q;
  endfunction

  function automatic logic [15:0] single_to_half(logic [31:0] x, logic clip);
    logic [15:0] sgn;
    logic [7:0]  bexp;
    logic [22:0] frac;
    logic [23:0] mant;
    int          e;
    sgn = {x[31], 15'd0};
    bexp = x[30:23];
    frac = x[22:0];
    e = int'(bexp) - 127;
    if (bexp == SingleExpMax) begin
      if (frac == 0) return sgn | 16'h7C00;
      mant = rne_shift({1'b0, frac}, 13) & 24'h3FF;
      if (frac[22]) mant[9] = 1'b1;
      else begin
        mant[9] = 1'b0;
        if (mant == 0) mant = 24'd1;
      end
      return sgn | 16'h7C00 | mant[15:0];
    end
    if (e < -25) return sgn;
    if (e < -14) begin
      mant = rne_shift({1'b1, frac}, -1 - e);
      return sgn | mant[15:0];
    end
    if (e <= 15) begin
      mant = rne_shift({1'b1, frac}, 13);
      if (mant[11]) begin
        mant = mant >> 1;
        e = e + 1;
      end
      if (e <= 15) return sgn | (16'(e + 15) << 10) | (mant[15:0] & 16'h3FF);
    end
    return sgn | (clip ? 16'h7BFF : 16'h7C00);
  endfunction

  // send one request, with random idle cycles before it; valid is left
  // for the next call or for drain to change in the same time step
  task automatic send_single(logic [31:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    single_bits <= x;
    expected_halves.push_back(single_to_half(x, clip_mode));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_halves.size() == 0) begin
        $error("unexpected result half_bits=%h", half_bits);
        failed = 1'b1;
      end else begin
        logic [15:0] want;
        want = expected_halves.pop_front();
        if (half_bits !== want) begin
          $error("half_bits mismatch: expected %h actual %h", want, half_bits);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_halves.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_clip(logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    clip_mode = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random word biased to interesting exponent bands and to near-half rounding tails
  function automatic logic [31:0] rand_single();
    logic [31:0] x;
    x = $urandom();
    case ($urandom_range(5))
      0: x[30:23] = 8'($urandom_range(100, 115));
      1: x[30:23] = 8'($urandom_range(138, 145));
      2: x[30:23] = 8'hFF;
      3: x[12:0] = ($urandom_range(1)) ? 13'h1000 : 13'h0FFF;
      default: x[30:23] = 8'($urandom_range(113, 142));
    endcase
    return x;
  endfunction

  task automatic test_directed;
    logic [31:0] vals[$];
    vals = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h3F80_0000,
             32'h3300_0000, 32'h3300_0001, 32'hB300_0000, 32'h3380_0000,
             32'h3880_0000, 32'h387F_F000, 32'h387F_E000, 32'h477F_E000,
             32'h477F_F000, 32'h4780_0000, 32'hC780_0000, 32'h7F80_0000,
             32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'h7F80_1000,
             32'h7FFF_FFFF, 32'hFFBF_F000, 32'h3F80_1000, 32'h3F80_3000,
             32'hFFFF_FFFF};
    foreach (vals[i]) send_single(vals[i]);
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_single(rand_single());
    drain();
  endtask

  task automatic test_backpressure;
    hold_off_cycles = 40;
    repeat (30) send_single(rand_single());
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_clip(1'b1);
    test_directed();
    test_random(400);
    send_idle_pct = 66;
    write_clip(1'b0);
    test_random(350);
    send_idle_pct = 0;
    recv_stall_pct = 66;
    write_clip(1'b1);
    test_random(350);
    send_idle_pct = 36;
    recv_stall_pct = 36;
    write_clip(1'b0);
    test_random(350);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    if (!failed) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

### files.f
sv/f2h_pkg.sv
sv/fp32_to_fp16_convert_top.sv
sim/fp32_to_fp16_convert_top_tb.sv
